/* rtl/idw_pkg.sv */
`timescale 1ns / 1ps

package idw_pkg;

   // Default depth of the request queue between front and back
   localparam int QUEUE_DEPTH_DEF = 2;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TIMEOUT    = 2'd1;

   // Register reset values
   localparam logic [7:0] DEVICE_ADDRESS_RST = 8'h78;
   localparam logic [7:0] ACK_TIMEOUT_RST    = 8'd250;

   // Control bytes that follow the address
   localparam logic [7:0] CTRL_DATA = 8'h40;
   localparam logic [7:0] CTRL_CMD  = 8'h00;

   // Position of the byte being sent inside the frame
   localparam logic [1:0] FPOS_ADDRESS = 2'd0;
   localparam logic [1:0] FPOS_CONTROL = 2'd1;
   localparam logic [1:0] FPOS_PAYLOAD = 2'd2;

   // Step numbers inside start, ack and stop sequences, and inside a bit
   localparam logic [1:0] STEP_0 = 2'd0;
   localparam logic [1:0] STEP_1 = 2'd1;
   localparam logic [1:0] STEP_2 = 2'd2;
   localparam logic [1:0] STEP_3 = 2'd3;

   localparam logic [2:0] LAST_BIT = 3'd7;

   // Request opcodes
   localparam logic OPC_TICK = 1'b0;
   localparam logic OPC_BYTE = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_START = 3'd1,
      PH_BITS  = 3'd2,
      PH_ACK   = 3'd3,
      PH_STOP  = 3'd4,
      PH_HOLD  = 3'd5
   } phase_type;

   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_BYTE = 1'b1
   } kind_type;

   // Classified request as it travels through the queue
   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload;
      logic       is_data;
      logic       opens;
      logic       closes;
      logic       sda_in;
   } queue_item_type;

   // Queue status seen by the top level
   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_stat_type;

   // A pin sequence is running
   function automatic logic phase_busy(input phase_type ph);
      return ph inside {PH_START, PH_BITS, PH_ACK, PH_STOP};
   endfunction

endpackage

/* rtl/i2c_display_write_master.sv */
`timescale 1ns / 1ps

// Write-only I2C master for a display controller, paced by tick requests.
// Every request on req_ gives exactly one response on rsp_. The response
// carries the pin levels after that step plus handshake and status flags.
// Requests pass through a small queue (QUEUE_DEPTH entries) into the pin
// sequencer, which carries out one request per cycle into an output register.
// A request accepted is first written into the queue; once popped it is carried
// out into the output register, and its response is on rsp_ from then on.
// One request per cycle is sustained as long as rsp_ready stays high.
// The bus bit rate is set entirely by how often ticks are sent. Registers
// are written through csr_ with csr_ready always high; index 0 is the
// device address byte, index 1 the ack poll limit, other indexes are ignored.

module i2c_display_write_master #(
   parameter int QUEUE_DEPTH = idw_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [idw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_opcode,
   input  logic [7:0]                      req_payload,
   input  logic                            req_is_data,
   input  logic                            req_opens,
   input  logic                            req_closes,
   input  logic                            req_sda_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_scl,
   output logic                            rsp_sda_out,
   output logic                            rsp_sda_drive,
   output logic                            rsp_accepted,
   output logic                            rsp_ready_res,
   output logic                            rsp_nack_error,
   output logic                            rsp_busy_res
);
   import idw_pkg::*;

   queue_item_type q_item;
   queue_stat_type q_stat;
   logic           q_valid, q_ready;

   // Front: accept and classify into the queue
   idw_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_payload (req_payload),
      .req_is_data (req_is_data),
      .req_opens   (req_opens),
      .req_closes  (req_closes),
      .req_sda_in  (req_sda_in),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_item      (q_item),
      .q_stat      (q_stat)
   );

   // Back: pin sequencer and response register
   idw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_item         (q_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_scl        (rsp_scl),
      .rsp_sda_out    (rsp_sda_out),
      .rsp_sda_drive  (rsp_sda_drive),
      .rsp_accepted   (rsp_accepted),
      .rsp_ready_res  (rsp_ready_res),
      .rsp_nack_error (rsp_nack_error),
      .rsp_busy_res   (rsp_busy_res)
   );

   // A pushed request is still queued on the next cycle
   a_push_held: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> q_stat.not_empty)
      else $error("queue lost a request");

   // Every request carried out produces a response
   a_pop_rsp: assert property (@(posedge clock) disable iff (reset)
      q_valid && q_ready |=> rsp_valid)
      else $error("response missing after queue pop");

   // Queue never reports full and empty together
   a_queue_stat: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> q_stat.not_empty)
      else $error("queue full while empty");

   // Ready and busy flags are complementary on a shown response
   a_ready_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ready_res != rsp_busy_res))
      else $error("ready and busy flags disagree");

endmodule

/* rtl/idw_front.sv */
`timescale 1ns / 1ps

module idw_front #(
   parameter int QUEUE_DEPTH = idw_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_opcode,
   input  logic [7:0]              req_payload,
   input  logic                    req_is_data,
   input  logic                    req_opens,
   input  logic                    req_closes,
   input  logic                    req_sda_in,
   output logic                    q_valid,
   input  logic                    q_ready,
   output idw_pkg::queue_item_type q_item,
   output idw_pkg::queue_stat_type q_stat
);
   import idw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   queue_item_type   entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   queue_item_type   item_cls;
   logic             push, pop;

   // Classify the incoming request
   always_comb begin
      item_cls.kind    = (req_opcode == OPC_BYTE) ? KIND_BYTE : KIND_TICK;
      item_cls.payload = req_payload;
      item_cls.is_data = req_is_data;
      item_cls.opens   = req_opens;
      item_cls.closes  = req_closes;
      item_cls.sda_in  = req_sda_in;
   end

   assign req_ready      = (count_ff != CNT_FULL);
   assign push           = req_valid && req_ready;
   assign q_valid        = (count_ff != '0);
   assign pop            = q_valid && q_ready;
   assign q_item         = entry_ff[rd_ptr_ff];
   assign q_stat.not_empty = q_valid;
   assign q_stat.full      = !req_ready;

   // Pointer and fill count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_cls;
      end
   end

endmodule

/* rtl/idw_back.sv */
`timescale 1ns / 1ps

module idw_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [idw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]              csr_wdata,
   input  logic                    q_valid,
   output logic                    q_ready,
   input  idw_pkg::queue_item_type q_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_scl,
   output logic                    rsp_sda_out,
   output logic                    rsp_sda_drive,
   output logic                    rsp_accepted,
   output logic                    rsp_ready_res,
   output logic                    rsp_nack_error,
   output logic                    rsp_busy_res
);
   import idw_pkg::*;

   // Configuration registers
   logic [7:0] dev_addr_ff, ack_timeout_ff;

   // Engine state
   phase_type  phase_ff, phase_in;
   logic [1:0] step_ff, step_in;
   logic [2:0] bit_cnt_ff, bit_cnt_in;
   logic [7:0] shift_ff, shift_in;
   logic [1:0] fpos_ff, fpos_in;
   logic [7:0] held_payload_ff, held_payload_in;
   logic       held_is_data_ff, held_is_data_in;
   logic       close_pending_ff, close_pending_in;
   logic [7:0] poll_cnt_ff, poll_cnt_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in_lvl;
   logic       drive_ff, drive_in;
   logic       error_ff, error_in;
   logic       discard_ff, discard_in;
   logic       accepted_in;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_scl_ff, rsp_sda_out_ff, rsp_sda_drive_ff, rsp_accepted_ff;
   logic       rsp_ready_res_ff, rsp_nack_error_ff, rsp_busy_res_ff;

   logic       fire;

   assign csr_ready = 1'b1;
   assign q_ready   = !rsp_valid_ff || rsp_ready;
   assign fire      = q_valid && q_ready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff    <= DEVICE_ADDRESS_RST;
         ack_timeout_ff <= ACK_TIMEOUT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS: dev_addr_ff    <= csr_wdata;
            CSR_ACK_TIMEOUT:    ack_timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state of the pin sequencer
   always_comb begin
      phase_in         = phase_ff;
      step_in          = step_ff;
      bit_cnt_in       = bit_cnt_ff;
      shift_in         = shift_ff;
      fpos_in          = fpos_ff;
      held_payload_in  = held_payload_ff;
      held_is_data_in  = held_is_data_ff;
      close_pending_in = close_pending_ff;
      poll_cnt_in      = poll_cnt_ff;
      scl_in           = scl_ff;
      sda_in_lvl       = sda_ff;
      drive_in         = drive_ff;
      error_in         = error_ff;
      discard_in       = discard_ff;
      accepted_in      = 1'b0;

      if (fire) begin
         if (q_item.kind == KIND_TICK) begin
            case (phase_ff)
               PH_START: begin
                  case (step_ff)
                     STEP_0: begin
                        drive_in = 1'b1; sda_in_lvl = 1'b1; step_in = STEP_1;
                     end
                     STEP_1: begin
                        scl_in = 1'b1; step_in = STEP_2;
                     end
                     STEP_2: begin
                        sda_in_lvl = 1'b0; step_in = STEP_3;
                     end
                     default: begin
                        // start done, address byte follows
                        scl_in     = 1'b0;
                        shift_in   = dev_addr_ff;
                        fpos_in    = FPOS_ADDRESS;
                        phase_in   = PH_BITS;
                        step_in    = STEP_0;
                        bit_cnt_in = '0;
                     end
                  endcase
               end
               PH_BITS: begin
                  case (step_ff)
                     STEP_0: begin
                        drive_in   = 1'b1;
                        sda_in_lvl = shift_ff[7];
                        shift_in   = {shift_ff[6:0], 1'b0};
                        step_in    = STEP_1;
                     end
                     STEP_1: begin
                        scl_in = 1'b1; step_in = STEP_2;
                     end
                     default: begin
                        scl_in     = 1'b0;
                        step_in    = STEP_0;
                        bit_cnt_in = bit_cnt_ff + 3'd1;
                        if (bit_cnt_ff == LAST_BIT) begin
                           phase_in = PH_ACK;
                        end
                     end
                  endcase
               end
               PH_ACK: begin
                  case (step_ff)
                     STEP_0: begin
                        drive_in = 1'b1; sda_in_lvl = 1'b1; step_in = STEP_1;
                     end
                     STEP_1: begin
                        drive_in = 1'b0; step_in = STEP_2;
                     end
                     STEP_2: begin
                        scl_in = 1'b1; poll_cnt_in = '0; step_in = STEP_3;
                     end
                     default: begin
                        if (!q_item.sda_in) begin
                           // acknowledged: next byte of the frame or finish
                           scl_in = 1'b0;
                           case (fpos_ff)
                              FPOS_ADDRESS: begin
                                 shift_in   = held_is_data_ff ? CTRL_DATA : CTRL_CMD;
                                 fpos_in    = FPOS_CONTROL;
                                 phase_in   = PH_BITS;
                                 step_in    = STEP_0;
                                 bit_cnt_in = '0;
                              end
                              FPOS_CONTROL: begin
                                 shift_in   = held_payload_ff;
                                 fpos_in    = FPOS_PAYLOAD;
                                 phase_in   = PH_BITS;
                                 step_in    = STEP_0;
                                 bit_cnt_in = '0;
                              end
                              default: begin
                                 phase_in = close_pending_ff ? PH_STOP : PH_HOLD;
                                 step_in  = STEP_0;
                              end
                           endcase
                        end else if (poll_cnt_ff >= ack_timeout_ff) begin
                           // no ack in time: stop and flag
                           error_in   = 1'b1;
                           discard_in = !close_pending_ff;
                           phase_in   = PH_STOP;
                           step_in    = STEP_0;
                        end else begin
                           poll_cnt_in = poll_cnt_ff + 8'd1;
                        end
                     end
                  endcase
               end
               PH_STOP: begin
                  case (step_ff)
                     STEP_0: begin
                        drive_in = 1'b1; scl_in = 1'b0; step_in = STEP_1;
                     end
                     STEP_1: begin
                        sda_in_lvl = 1'b0; step_in = STEP_2;
                     end
                     STEP_2: begin
                        scl_in = 1'b1; step_in = STEP_3;
                     end
                     default: begin
                        sda_in_lvl = 1'b1; phase_in = PH_IDLE; step_in = STEP_0;
                     end
                  endcase
               end
               default: ;
            endcase
         end else if (!phase_busy(phase_ff)) begin
            accepted_in = 1'b1;
            if (q_item.opens || (phase_ff != PH_HOLD && !discard_ff)) begin
               // new transaction (or repeated start)
               held_payload_in  = q_item.payload;
               held_is_data_in  = q_item.is_data;
               close_pending_in = q_item.closes;
               error_in         = 1'b0;
               discard_in       = 1'b0;
               phase_in         = PH_START;
               step_in          = STEP_0;
            end else if (phase_ff == PH_HOLD) begin
               // next payload byte within the open transaction
               close_pending_in = q_item.closes;
               held_payload_in  = q_item.payload;
               shift_in         = q_item.payload;
               fpos_in          = FPOS_PAYLOAD;
               phase_in         = PH_BITS;
               step_in          = STEP_0;
               bit_cnt_in       = '0;
            end else if (q_item.closes) begin
               // dropped byte ends the failed transaction
               discard_in = 1'b0;
            end
         end
      end
   end

   // Result valid flag: set by each step carried out, held until rsp_ready
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         step_ff          <= STEP_0;
         bit_cnt_ff       <= '0;
         shift_ff         <= '0;
         fpos_ff          <= FPOS_ADDRESS;
         held_payload_ff  <= '0;
         held_is_data_ff  <= 1'b0;
         close_pending_ff <= 1'b0;
         poll_cnt_ff      <= '0;
         scl_ff           <= 1'b1;
         sda_ff           <= 1'b1;
         drive_ff         <= 1'b1;
         error_ff         <= 1'b0;
         discard_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         step_ff          <= step_in;
         bit_cnt_ff       <= bit_cnt_in;
         shift_ff         <= shift_in;
         fpos_ff          <= fpos_in;
         held_payload_ff  <= held_payload_in;
         held_is_data_ff  <= held_is_data_in;
         close_pending_ff <= close_pending_in;
         poll_cnt_ff      <= poll_cnt_in;
         scl_ff           <= scl_in;
         sda_ff           <= sda_in_lvl;
         drive_ff         <= drive_in;
         error_ff         <= error_in;
         discard_ff       <= discard_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Output register, loaded when a queued request is carried out
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_scl_ff        <= scl_in;
         rsp_sda_out_ff    <= sda_in_lvl;
         rsp_sda_drive_ff  <= drive_in;
         rsp_accepted_ff   <= accepted_in;
         rsp_ready_res_ff  <= !phase_busy(phase_in);
         rsp_nack_error_ff <= error_in;
         rsp_busy_res_ff   <= phase_busy(phase_in);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl        = rsp_scl_ff;
   assign rsp_sda_out    = rsp_sda_out_ff;
   assign rsp_sda_drive  = rsp_sda_drive_ff;
   assign rsp_accepted   = rsp_accepted_ff;
   assign rsp_ready_res  = rsp_ready_res_ff;
   assign rsp_nack_error = rsp_nack_error_ff;
   assign rsp_busy_res   = rsp_busy_res_ff;

endmodule
